// ----- rtl/fncrc_pkg.sv -----
package fncrc_pkg;

  localparam int unsigned CRC_W = 32;
  localparam int unsigned CHAR_W = 8;

  localparam logic [CRC_W-1:0] CRC_GENERATOR = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] CRC_START = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_OUT_XOR = 32'h0000_0000;

  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_CASE_OFS = 8'h20;

  typedef logic [CRC_W-1:0] crc_t;
  typedef logic [CRC_W-1:0][CRC_W-1:0] aug_tbl_t;

  // slash to backslash, upper to lower, everything else passes
  function automatic logic [CHAR_W-1:0] norm_char(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] c;
    c = ch;
    if (c == CH_SLASH) c = CH_BSLASH;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + CH_CASE_OFS;
    return c;
  endfunction

  // msb-first crc over one byte, eight shift steps
  function automatic crc_t crc_byte(input crc_t c_in, input logic [CHAR_W-1:0] b);
    crc_t c;
    c = c_in ^ {b, {(CRC_W-CHAR_W){1'b0}}};
    for (int k = 0; k < CHAR_W; k++) begin
      if (c[CRC_W-1]) c = (c << 1) ^ CRC_GENERATOR;
      else            c = c << 1;
    end
    return c;
  endfunction

  // column i is the effect of bit i after 32 zero bits, i.e. x^(32+i) mod poly
  function automatic aug_tbl_t build_aug_tbl();
    aug_tbl_t t;
    crc_t c;
    for (int i = 0; i < CRC_W; i++) begin
      c = crc_t'(1) << i;
      for (int k = 0; k < CRC_W; k++) begin
        if (c[CRC_W-1]) c = (c << 1) ^ CRC_GENERATOR;
        else            c = c << 1;
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam aug_tbl_t AUG_TBL = build_aug_tbl();

  // four zero bytes through the crc, as one xor network
  function automatic crc_t crc_augment(input crc_t c);
    crc_t r;
    r = '0;
    for (int i = 0; i < CRC_W; i++) begin
      if (c[i]) r = r ^ AUG_TBL[i];
    end
    return r;
  endfunction

endpackage

// ----- rtl/fncrc_if.sv -----
interface fncrc_in_if;
  logic                         valid;
  logic                         ready;
  logic [fncrc_pkg::CHAR_W-1:0] char_byte;
  logic                         has_char;
  logic                         is_last;

  modport source (output valid, output char_byte, output has_char, output is_last,
                  input ready);
  modport sink (input valid, input char_byte, input has_char, input is_last,
                output ready);
endinterface

interface fncrc_out_if;
  logic                        valid;
  logic                        ready;
  logic [fncrc_pkg::CRC_W-1:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink (input valid, input crc_value, output ready);
endinterface

// ----- rtl/filename_crc32_normalized.sv -----
// channel  dir  payload                            beat
// in_ch    in   char_byte[7:0] has_char is_last     valid & ready
// out_ch   out  crc_value[31:0]                    valid & ready
//
// one beat per cycle unless held: input register, byte crc and augmentation
// network, result register; the running crc register closes the loop
// a beat without is_last passes even while a result waits on out_ch
// a last beat holds in the input register until the result register is free
// reset (rst_n low, synchronous) loads the running crc with all ones
module filename_crc32_normalized (
  input  logic        clk,
  input  logic        rst_n,
  fncrc_in_if.sink    in_ch,
  fncrc_out_if.source out_ch
);

  logic                         s1_valid_r;
  logic [fncrc_pkg::CHAR_W-1:0] s1_char_r;
  logic                         s1_has_r;
  logic                         s1_last_r;

  fncrc_pkg::crc_t crc_r, crc_nxt;
  logic            out_valid_r;
  fncrc_pkg::crc_t out_crc_r;

  fncrc_pkg::crc_t crc_upd;
  logic            out_free;
  logic            s1_fire;
  logic            in_fire;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_comb begin
    crc_upd = s1_has_r ? fncrc_pkg::crc_byte(crc_r, fncrc_pkg::norm_char(s1_char_r))
                       : crc_r;
    crc_nxt = crc_r;
    if (s1_fire) crc_nxt = s1_last_r ? fncrc_pkg::CRC_START : crc_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= fncrc_pkg::CRC_START;
    end else begin
      crc_r <= crc_nxt;
      if (in_fire)      s1_valid_r <= 1'b1;
      else if (s1_fire) s1_valid_r <= 1'b0;
      if (s1_fire && s1_last_r) out_valid_r <= 1'b1;
      else if (out_ch.ready)    out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_ch.char_byte;
      s1_has_r  <= in_ch.has_char;
      s1_last_r <= in_ch.is_last;
    end
    if (s1_fire && s1_last_r)
      out_crc_r <= fncrc_pkg::crc_augment(crc_upd) ^ fncrc_pkg::CRC_OUT_XOR;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.crc_value = out_crc_r;

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (crc_r == fncrc_pkg::CRC_START))
    else $error("running crc not reloaded after end of string");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && s1_last_r))
    else $error("result appeared without an end-of-string beat");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a blocked last beat");

  a_crc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(crc_r))
    else $error("running crc changed with no beat consumed");

endmodule

// ----- verif/filename_crc32_normalized_tb.sv -----
module filename_crc32_normalized_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // expected path crc values, kept in the order the strings were closed
  class path_crc_board;
    fncrc_pkg::crc_t running;
    fncrc_pkg::crc_t crc_expected_q[$];
    int unsigned     errors;
    int unsigned     checked;

    function new();
      running = fncrc_pkg::CRC_START;
      errors  = 0;
      checked = 0;
    endfunction

    function logic [fncrc_pkg::CHAR_W-1:0] fold_char(
      input logic [fncrc_pkg::CHAR_W-1:0] ch);
      logic [fncrc_pkg::CHAR_W-1:0] r;
      r = (ch == fncrc_pkg::CH_SLASH) ? fncrc_pkg::CH_BSLASH : ch;
      if (r >= fncrc_pkg::CH_UPPER_A && r <= fncrc_pkg::CH_UPPER_Z)
        r = r + fncrc_pkg::CH_CASE_OFS;
      return r;
    endfunction

    function fncrc_pkg::crc_t shift_byte(input fncrc_pkg::crc_t c_in,
                                         input logic [fncrc_pkg::CHAR_W-1:0] b);
      fncrc_pkg::crc_t c;
      c = c_in;
      c[fncrc_pkg::CRC_W-1 -: fncrc_pkg::CHAR_W] =
        c[fncrc_pkg::CRC_W-1 -: fncrc_pkg::CHAR_W] ^ b;
      for (int k = 0; k < fncrc_pkg::CHAR_W; k++)
        c = c[fncrc_pkg::CRC_W-1] ? ((c << 1) ^ fncrc_pkg::CRC_GENERATOR) : (c << 1);
      return c;
    endfunction

    function void note_beat(input logic [fncrc_pkg::CHAR_W-1:0] ch, input logic has,
                            input logic fin);
      fncrc_pkg::crc_t c;
      if (has) running = shift_byte(running, fold_char(ch));
      if (fin) begin
        c = running;
        for (int k = 0; k < 4; k++) c = shift_byte(c, '0);
        crc_expected_q.push_back(c ^ fncrc_pkg::CRC_OUT_XOR);
        running = fncrc_pkg::CRC_START;
      end
    endfunction

    function void check_result(input fncrc_pkg::crc_t got);
      fncrc_pkg::crc_t want;
      if (crc_expected_q.size() == 0) begin
        $error("crc_value: no result expected, got %08h", got);
        errors++;
        return;
      end
      want = crc_expected_q.pop_front();
      checked++;
      if (got !== want) begin
        $error("crc_value mismatch: expected %08h, got %08h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fncrc_in_if  in_bus ();
  fncrc_out_if out_bus ();

  filename_crc32_normalized i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  path_crc_board board = new();

  bit          tx_fast = 1'b0;
  bit          rx_fast = 1'b0;
  int unsigned char_beats = 0;
  int unsigned strings_sent = 0;
  int unsigned empty_strings = 0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin : watchdog
    #5_000_000;
    $display("FAIL filename_crc32_normalized");
    $finish;
  end

  task automatic send_beat(input logic [fncrc_pkg::CHAR_W-1:0] ch, input logic has,
                           input logic fin);
    int unsigned gap;
    gap = tx_fast ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.char_byte = ch;
    in_bus.has_char  = has;
    in_bus.is_last   = fin;
    in_bus.valid     = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    board.note_beat(ch, has, fin);
    if (has) char_beats++;
    if (fin) strings_sent++;
    if (fin && !has) empty_strings++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (board.crc_expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [fncrc_pkg::CHAR_W-1:0] pick_char();
    case ($urandom_range(0, 6))
      0:       return fncrc_pkg::CH_UPPER_A + fncrc_pkg::CHAR_W'($urandom_range(0, 25));
      1:       return 8'h61 + fncrc_pkg::CHAR_W'($urandom_range(0, 25));
      2:       return fncrc_pkg::CH_SLASH;
      3:       return fncrc_pkg::CH_BSLASH;
      4:       return 8'h2E + fncrc_pkg::CHAR_W'($urandom_range(0, 11));
      default: return fncrc_pkg::CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    logic [fncrc_pkg::CHAR_W-1:0] singles [12];
    int unsigned                  len;
    int unsigned                  counted;
    bit                           close_on_char;

    singles = '{8'h41, 8'h5A, 8'h40, 8'h5B, 8'h2F, 8'h5C,
                8'h61, 8'h7A, 8'h00, 8'hFF, 8'h80, 8'h7F};
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.char_byte = '0;
    in_bus.has_char  = 1'b0;
    in_bus.is_last   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty string, then an ignored beat before another empty one
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    // single chars around the case and slash boundaries, zero and high bytes
    foreach (singles[i]) send_beat(singles[i], 1'b1, 1'b1);
    // mixed case and a slash in one string
    send_beat(8'h41, 1'b1, 1'b0);
    send_beat(8'h2F, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b1);
    // zero byte inside a string does not end it
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h78, 1'b1, 1'b1);
    // end of string on a beat with no char, payload byte must be ignored
    send_beat(8'h51, 1'b1, 1'b0);
    send_beat(8'hAB, 1'b0, 1'b0);
    send_beat(8'h55, 1'b0, 1'b1);
    wait_drained();

    counted = 0;
    while (counted < 1750) begin
      if ($urandom_range(0, 3) == 0) tx_fast = !tx_fast;
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 64) : $urandom_range(0, 12);
      close_on_char = (len != 0) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_beat(fncrc_pkg::CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_beat(pick_char(), 1'b1, close_on_char && (i == len - 1));
        counted++;
      end
      if (!close_on_char) begin
        send_beat(fncrc_pkg::CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        counted++;
      end
      if ($urandom_range(0, 39) == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (board.crc_expected_q.size() != 0) begin
      $error("crc_value: %0d results never arrived", board.crc_expected_q.size());
      board.errors++;
    end

    $display("sent %0d strings (%0d empty) with %0d chars, %0d crc values checked",
             strings_sent, empty_strings, char_beats, board.checked);
    if (board.errors == 0) begin
      $display("PASS filename_crc32_normalized");
    end else begin
      $display("FAIL filename_crc32_normalized");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = rx_fast ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_bus.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready = 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      board.check_result(out_bus.crc_value);
      @(negedge clk);
      if ($urandom_range(0, 15) == 0) rx_fast = !rx_fast;
    end
  end

endmodule

// ----- filelist.f -----
rtl/fncrc_pkg.sv
rtl/fncrc_if.sv
rtl/filename_crc32_normalized.sv
verif/filename_crc32_normalized_tb.sv
